FILE: hdl/lmqs_pkg.sv
// lmqs_pkg: shared types and constants for the quarter-scan led matrix driver
// used by led_matrix_quarter_scan_driver_top; no dependencies

package lmqs_pkg;

   localparam logic [1:0] REQ_SET_PIXEL = 2'd0;
   localparam logic [1:0] REQ_CLEAR     = 2'd1;
   localparam logic [1:0] REQ_REFRESH   = 2'd2;

   localparam int SHIFT_LANES = 4;
   localparam int MAX_RESULTS = 32;
   localparam int ROW_SUM_W   = 7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_LOAD,
      ST_DRAIN,
      ST_EMIT
   } state_type;

endpackage

FILE: hdl/led_matrix_quarter_scan_driver_top.sv
// led_matrix_quarter_scan_driver_top: frame store and scan sequencer of a quarter-scan panel
// depends on lmqs_pkg
//
// request channel (req_*): one word per request, taken only while the block is idle.
//    set pixel: the row is read from the frame memory and written back merged in the
//       write state; coordinates off the panel are dropped
//    clear: every row is marked blank at once, the next request is taken in the following cycle
//    refresh: the rows of the current scan group are read from the frame memory one per
//       cycle into four column buffers (one read per lane, then a drain state for the last read data),
//       then one result word per column is emitted, highest column first
// result channel (rsp_*): a registered output slot; with rsp_ready held high a refresh
//    gives its first word after the load and drain states and then one word per cycle;
//    a refresh covers N columns (N at most 32). the single port of the frame memory sets
//    the load phase. the word for column 0 carries rsp_latch_now, after which the scan
//    group advances
// stalls: while rsp_ready is low the pending word holds and emission pauses; the last word
//    of a refresh may still wait in the slot while the next request is accepted
// reset: synchronous, active high; the frame reads as all dark, the scan group is 0,
//    and a request can be taken in the first cycle after reset

module led_matrix_quarter_scan_driver_top #(
   parameter int PANEL_WIDTH  = 32,
   parameter int PANEL_HEIGHT = 16,
   parameter int SCAN_GROUPS  = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic [4:0] req_pix_x,
   input  logic [3:0] req_pix_y,
   input  logic       req_pix_on,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_row_select,
   output logic [4:0] rsp_column,
   output logic [3:0] rsp_shift_bits,
   output logic       rsp_latch_now
);

   localparam int NCOLS = (PANEL_WIDTH > lmqs_pkg::MAX_RESULTS) ?
                          lmqs_pkg::MAX_RESULTS : PANEL_WIDTH;
   localparam int COL_W = $clog2(NCOLS);
   localparam int XW    = $clog2(PANEL_WIDTH);
   localparam int ROW_W = $clog2(PANEL_HEIGHT);
   localparam int GRP_W = $clog2(SCAN_GROUPS);
   localparam int SW    = lmqs_pkg::ROW_SUM_W;

   lmqs_pkg::state_type state_ff, state_in;

   logic [PANEL_WIDTH-1:0] mem [PANEL_HEIGHT];
   logic [PANEL_HEIGHT-1:0] row_vld_ff;

   logic [PANEL_WIDTH-1:0] rd_data_ff;
   logic                   rd_ok_ff;
   logic [ROW_W-1:0]       rd_addr;
   logic                   rd_ok;

   logic [ROW_W-1:0]       wr_row_ff;
   logic [XW-1:0]          wr_x_ff;
   logic                   wr_on_ff;
   logic [PANEL_WIDTH-1:0] row_merge;

   logic [NCOLS-1:0] lane_ff [lmqs_pkg::SHIFT_LANES];
   logic [1:0]       k_ff;
   logic [1:0]       cap_k_ff;
   logic             cap_en_ff;
   logic [SW-1:0]    row_sum;

   logic [COL_W-1:0] col_ff;
   logic [GRP_W-1:0] grp_ff;
   logic [3:0]       bits_in;

   logic       rsp_valid_ff;
   logic [1:0] rsp_row_select_ff;
   logic [4:0] rsp_column_ff;
   logic [3:0] rsp_shift_bits_ff;
   logic       rsp_latch_now_ff;

   logic req_take;
   logic in_panel;
   logic rsp_load;

   assign req_take = req_valid && req_ready;
   assign in_panel = (7'(req_pix_x) < 7'(PANEL_WIDTH)) && (7'(req_pix_y) < 7'(PANEL_HEIGHT));
   assign rsp_load = (state_ff == lmqs_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign row_sum  = SW'(grp_ff) + SW'(k_ff) * SW'(SCAN_GROUPS);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lmqs_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_type == lmqs_pkg::REQ_SET_PIXEL && in_panel) begin
                  state_in = lmqs_pkg::ST_WRITE;
               end else if (req_type == lmqs_pkg::REQ_REFRESH) begin
                  state_in = lmqs_pkg::ST_LOAD;
               end
            end
         end
         lmqs_pkg::ST_WRITE: state_in = lmqs_pkg::ST_IDLE;
         lmqs_pkg::ST_LOAD: begin
            if (k_ff == 2'(lmqs_pkg::SHIFT_LANES - 1)) begin
               state_in = lmqs_pkg::ST_DRAIN;
            end
         end
         lmqs_pkg::ST_DRAIN: state_in = lmqs_pkg::ST_EMIT;
         lmqs_pkg::ST_EMIT: begin
            if (rsp_load && col_ff == '0) begin
               state_in = lmqs_pkg::ST_IDLE;
            end
         end
         default: state_in = lmqs_pkg::ST_IDLE;
      endcase
   end

   // memory read address and handshake outputs
   always_comb begin
      req_ready = 1'b0;
      rd_addr   = ROW_W'(req_pix_y);
      rd_ok     = 1'b0;
      case (state_ff)
         lmqs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            rd_ok     = 7'(req_pix_y) < 7'(PANEL_HEIGHT);
         end
         lmqs_pkg::ST_LOAD: begin
            rd_addr = row_sum[ROW_W-1:0];
            rd_ok   = row_sum < SW'(PANEL_HEIGHT);
         end
         default: begin
            rd_ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      row_merge = rd_ok_ff ? rd_data_ff : '0;
      row_merge[wr_x_ff] = wr_on_ff;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (state_ff == lmqs_pkg::ST_WRITE) begin
         mem[wr_row_ff] <= row_merge;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= lmqs_pkg::ST_IDLE;
         row_vld_ff <= '0;
         rd_ok_ff   <= 1'b0;
         cap_en_ff  <= 1'b0;
         k_ff       <= '0;
         grp_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         rd_ok_ff  <= rd_ok && row_vld_ff[rd_addr];
         cap_en_ff <= (state_ff == lmqs_pkg::ST_LOAD);
         if (state_ff == lmqs_pkg::ST_WRITE) begin
            row_vld_ff[wr_row_ff] <= 1'b1;
         end
         if (req_take && req_type == lmqs_pkg::REQ_CLEAR) begin
            row_vld_ff <= '0;
         end
         if (state_ff == lmqs_pkg::ST_LOAD) begin
            k_ff <= k_ff + 2'd1;
         end else begin
            k_ff <= '0;
         end
         if (rsp_load && col_ff == '0) begin
            grp_ff <= (grp_ff == GRP_W'(SCAN_GROUPS - 1)) ? '0 : grp_ff + GRP_W'(1);
         end
      end
   end

   // request capture, column buffers and column counter
   always_ff @(posedge clock) begin
      if (req_take) begin
         wr_row_ff <= ROW_W'(req_pix_y);
         wr_x_ff   <= XW'(req_pix_x);
         wr_on_ff  <= req_pix_on;
         col_ff    <= COL_W'(NCOLS - 1);
      end else if (rsp_load) begin
         col_ff <= col_ff - COL_W'(1);
      end
      cap_k_ff <= k_ff;
      if (cap_en_ff) begin
         lane_ff[cap_k_ff] <= rd_ok_ff ? rd_data_ff[NCOLS-1:0] : '0;
      end
   end

   always_comb begin
      for (int k = 0; k < lmqs_pkg::SHIFT_LANES; k++) begin
         bits_in[k] = lane_ff[k][col_ff];
      end
   end

   // output slot
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_row_select_ff <= 2'(grp_ff);
         rsp_column_ff     <= 5'(col_ff);
         rsp_shift_bits_ff <= bits_in;
         rsp_latch_now_ff  <= (col_ff == '0);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_select = rsp_row_select_ff;
   assign rsp_column     = rsp_column_ff;
   assign rsp_shift_bits = rsp_shift_bits_ff;
   assign rsp_latch_now  = rsp_latch_now_ff;

endmodule

FILE: hdl/lmqs_checker.sv
// lmqs_checker: port-level assertions for the quarter-scan led matrix driver
// depends on led_matrix_quarter_scan_driver_top, bound to it below

module lmqs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_type,
   input logic [4:0] req_pix_x,
   input logic [3:0] req_pix_y,
   input logic       req_pix_on,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_row_select,
   input logic [4:0] rsp_column,
   input logic [3:0] rsp_shift_bits,
   input logic       rsp_latch_now
);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_column) && $stable(rsp_shift_bits))
      else $error("stalled result word changed");

   a_latch_col0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_latch_now |-> rsp_column == 5'd0)
      else $error("latch flagged away from column 0");

   // mid-scan words come back to back with the column stepping down
   a_col_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_latch_now |=>
         rsp_valid && rsp_column == 5'($past(rsp_column) - 5'd1) &&
         rsp_row_select == $past(rsp_row_select))
      else $error("column sequence broken");

   a_busy_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_latch_now |-> !req_ready)
      else $error("request taken in the middle of a scan");

endmodule

bind led_matrix_quarter_scan_driver_top lmqs_checker u_lmqs_checker (.*);
